>>> design/unicode_escape_decoder_top_defines.svh
// assertion macros for the unicode escape decoder
`ifndef UNICODE_ESCAPE_DECODER_TOP_DEFINES_SVH
`define UNICODE_ESCAPE_DECODER_TOP_DEFINES_SVH

// same-cycle implication under clk and arst_n
`define UED_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication under clk and arst_n
`define UED_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> design/ued_pkg.sv
// types, character codes and helpers shared by the escape decoder modules
`default_nettype none

package ued_pkg;

	localparam int MAX_WIDE_DIGITS = 8;
	localparam int LEN_W = 4;
	localparam int IDX_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int NARROW_DIGITS = 4;

	localparam logic [20:0] CH_BACKSLASH = 21'h00005C;
	localparam logic [20:0] CH_UPPER_U = 21'h000055;
	localparam logic [20:0] CH_LOWER_U = 21'h000075;

	typedef struct packed {
		logic [LEN_W-1:0] pre_len;
		logic wide;
		logic [MAX_WIDE_DIGITS-1:0][6:0] digits;
		logic has_tail;
		logic [23:0] tail;
		logic tail_bs;
	} job_t;

	typedef struct packed {
		logic ok;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(logic [20:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.value = 4'h0;
		if (c >= 21'h30 && c <= 21'h39) begin
			h.value = 4'(c - 21'h30);
		end else if (c >= 21'h61 && c <= 21'h66) begin
			h.value = 4'(c - 21'h57);
		end else if (c >= 21'h41 && c <= 21'h46) begin
			h.value = 4'(c - 21'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

>>> design/ued_front.sv
// front end: takes items, tracks escape state and builds output jobs
`default_nettype none

module ued_front #(
	parameter int WIDE_DIGITS = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [20:0]    in_char,
	input  wire logic           end_of_text,
	output logic                push,
	output ued_pkg::job_t       job,
	input  wire logic           q_ready,
	output logic                pending
);
	import ued_pkg::*;

	localparam int SW = $clog2(WIDE_DIGITS + 2);
	localparam int DW = $clog2(WIDE_DIGITS);
	localparam logic [SW-1:0] ST_IDLE = SW'(0);
	localparam logic [SW-1:0] ST_BS = SW'(1);
	localparam logic [SW-1:0] ST_LETTER = SW'(2);

	logic [SW-1:0] stage_q, stage_d, need1;
	logic wide_q, wide_d;
	logic [23:0] accum_q, accum_d;
	logic [6:0] digits_q [WIDE_DIGITS];
	logic wr_en, as_idle, accept;
	logic [DW-1:0] widx;
	hex_t hx;

	assign in_ready = q_ready;
	assign accept = in_valid && in_ready;
	assign pending = stage_q != ST_IDLE;
	assign hx = hex_decode(in_char);
	assign need1 = wide_q ? SW'(WIDE_DIGITS + 1) : SW'(NARROW_DIGITS + 1);
	assign widx = DW'(stage_q - ST_LETTER);

	always_comb begin
		stage_d = stage_q;
		wide_d = wide_q;
		accum_d = accum_q;
		wr_en = 1'b0;
		as_idle = 1'b0;
		job = '0;
		if (stage_q == ST_IDLE) begin
			as_idle = 1'b1;
		end else if (stage_q == ST_BS) begin
			if (in_char == CH_UPPER_U || in_char == CH_LOWER_U) begin
				wide_d = in_char == CH_UPPER_U;
				accum_d = '0;
				stage_d = ST_LETTER;
			end else begin
				job.pre_len = LEN_W'(1);
				as_idle = 1'b1;
			end
		end else begin
			if (!hx.ok) begin
				job.pre_len = LEN_W'(stage_q);
				as_idle = 1'b1;
			end else begin
				accum_d = {accum_q[19:0], hx.value};
				if (stage_q >= need1) begin
					job.has_tail = 1'b1;
					job.tail = accum_d;
					stage_d = ST_IDLE;
				end else begin
					wr_en = 1'b1;
					stage_d = stage_q + SW'(1);
				end
			end
		end
		if (as_idle) begin
			if (in_char == CH_BACKSLASH) begin
				stage_d = ST_BS;
			end else begin
				job.has_tail = 1'b1;
				job.tail = 24'(in_char);
				stage_d = ST_IDLE;
			end
		end
		job.wide = wide_d;
		for (int k = 0; k < WIDE_DIGITS; k++) begin
			job.digits[k] = (wr_en && widx == DW'(k)) ? in_char[6:0] : digits_q[k];
		end
		// end of text flushes whatever escape is left
		if (end_of_text) begin
			if (stage_d == ST_BS) begin
				job.tail_bs = 1'b1;
			end else if (stage_d != ST_IDLE) begin
				job.pre_len = LEN_W'(stage_d);
			end
			stage_d = ST_IDLE;
		end
	end

	assign push = accept && (job.pre_len != '0 || job.has_tail || job.tail_bs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_IDLE;
			wide_q <= 1'b0;
			accum_q <= '0;
		end else if (accept) begin
			stage_q <= stage_d;
			wide_q <= wide_d;
			accum_q <= accum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			digits_q[widx] <= in_char[6:0];
		end
	end

endmodule

`default_nettype wire

>>> design/ued_queue.sv
// short job queue between the front end and the output sequencer
`default_nettype none

module ued_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ued_pkg::job_t  push_job,
	output logic                ready,
	output logic                valid,
	output ued_pkg::job_t       head,
	input  wire logic           pop
);
	import ued_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign ready = count_q != CW'(QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

>>> design/ued_back.sv
// back end: walks one job at a time and drives the output register
`default_nettype none

module ued_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire ued_pkg::job_t  head,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [23:0]         out_char,
	output logic                run_last
);
	import ued_pkg::*;

	logic [LEN_W-1:0] pos_q, total;
	logic [23:0] sel, out_char_q;
	logic out_valid_q, run_last_q, is_last, load;

	assign total = head.pre_len + LEN_W'(head.has_tail) + LEN_W'(head.tail_bs);
	assign is_last = pos_q == total - LEN_W'(1);
	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop = load && is_last;

	always_comb begin
		if (pos_q < head.pre_len) begin
			if (pos_q == LEN_W'(0)) begin
				sel = 24'(CH_BACKSLASH);
			end else if (pos_q == LEN_W'(1)) begin
				sel = head.wide ? 24'(CH_UPPER_U) : 24'(CH_LOWER_U);
			end else begin
				sel = 24'(head.digits[IDX_W'(pos_q - LEN_W'(2))]);
			end
		end else if (pos_q == head.pre_len && head.has_tail) begin
			sel = head.tail;
		end else begin
			sel = 24'(CH_BACKSLASH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pos_q <= is_last ? '0 : pos_q + LEN_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= sel;
			run_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign run_last = run_last_q;

endmodule

`default_nettype wire

>>> design/unicode_escape_decoder_top.sv
// top level of the unicode escape decoder
`default_nettype none

// Replaces \uXXXX and \UX..X (WIDE_DIGITS hex digits) escapes in a character
// stream by the codepoint they spell; malformed or cut-off escapes come out
// literally, and a pending escape is flushed on end_of_text. An item is taken
// whenever the two-entry job queue has room; results leave the output
// register at one per cycle while out_ready stays high, so the output
// sequencer sets the sustained rate. Items that cause no result (an escape
// still being collected) push no job but still need room in the queue.
// run_last marks the final result of each item. No start-up pass.

`include "unicode_escape_decoder_top_defines.svh"

module unicode_escape_decoder_top #(
	parameter int WIDE_DIGITS = 6
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [20:0]    in_char,
	input  wire logic           end_of_text,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [23:0]         out_char,
	output logic                run_last
);
	import ued_pkg::*;

	job_t push_job, head;
	logic push, q_ready, q_valid, q_pop, pending;

	ued_front #(
		.WIDE_DIGITS(WIDE_DIGITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_char(in_char),
		.end_of_text(end_of_text),
		.push(push),
		.job(push_job),
		.q_ready(q_ready),
		.pending(pending)
	);

	ued_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.ready(q_ready),
		.valid(q_valid),
		.head(head),
		.pop(q_pop)
	);

	ued_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(q_valid),
		.head(head),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char(out_char),
		.run_last(run_last)
	);

	`UED_ASSERT_NEXT(a_eot_clears, in_valid && in_ready && end_of_text, !pending, "escape left pending after end of text")
	`UED_ASSERT_NEXT(a_pop_last, q_pop, out_valid && run_last, "job retired without a final item")
	`UED_ASSERT_NOW(a_out_from_job, $rose(out_valid), $past(q_valid), "output appeared without a queued job")

endmodule

`default_nettype wire
